>>> rtl/core/cached_nearest_palette_color_top_defines.svh
// Assertion macros used by the top RTL file of the nearest palette color block.
`ifndef CACHED_NEAREST_PALETTE_COLOR_TOP_DEFINES_SVH
`define CACHED_NEAREST_PALETTE_COLOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CNPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CNPC_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);
`else
`define CNPC_ASSERT(label, prop, msg)
`define CNPC_ASSERT_NEXT(label, cause, effect, msg)
`endif

`endif

>>> rtl/core/cnpc_pkg.sv
package cnpc_pkg;

  localparam int CACHE_ENTRIES   = 32;
  localparam int PALETTE_ENTRIES = 256;
  localparam int SWAP_ABOVE      = 4;
  localparam int LFSR_BITS       = 15;
  localparam int COMP_W          = 6;
  localparam int IDX_W           = 8;
  localparam int CFG_W           = 8;

  localparam int CACHE_AW = $clog2(CACHE_ENTRIES);
  localparam int FILL_W   = $clog2(CACHE_ENTRIES + 1);
  localparam int PAL_AW   = $clog2(PALETTE_ENTRIES);
  localparam int DIST_W   = 2 * COMP_W + 2;

  localparam logic [CFG_W-1:0]     LAST_INDEX_RESET = 8'd253;
  localparam logic [LFSR_BITS-1:0] LFSR_RESET       = 15'd1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } color_t;

  typedef struct packed {
    color_t            color;
    logic [PAL_AW-1:0] idx;
  } cache_entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CSCAN = 6'b000010,
    ST_SWAP  = 6'b000100,
    ST_PSCAN = 6'b001000,
    ST_STORE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

endpackage

>>> rtl/core/cnpc_ram.sv
module cnpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/cnpc_dist.sv
module cnpc_dist (
  input  cnpc_pkg::color_t              query,
  input  cnpc_pkg::color_t              entry,
  output logic [cnpc_pkg::DIST_W-1:0]   sq_dist
);

  logic [cnpc_pkg::COMP_W-1:0]   dr, dg, db;
  logic [2*cnpc_pkg::COMP_W-1:0] sr, sg, sb;

  assign dr = (query.r > entry.r) ? query.r - entry.r : entry.r - query.r;
  assign dg = (query.g > entry.g) ? query.g - entry.g : entry.g - query.g;
  assign db = (query.b > entry.b) ? query.b - entry.b : entry.b - query.b;

  assign sr = dr * dr;
  assign sg = dg * dg;
  assign sb = db * db;

  assign sq_dist = cnpc_pkg::DIST_W'(sr) + cnpc_pkg::DIST_W'(sg) + cnpc_pkg::DIST_W'(sb);

endmodule

>>> rtl/core/cached_nearest_palette_color_top.sv
// Channel   Handshake                Word
// config    cfg_write_en             cfg_write_data (last searched index)
// input     in_valid / in_ready      kind, entry_index, red, green, blue
// output    out_valid / out_ready    color_index, cache_hit
//
// A palette write produces no output word.
// A lookup that hits a cache position above 4 also moves that entry one place forward.
// A miss runs the cache scan (skipped while the cache is empty) and then the palette scan,
// one palette entry per cycle through the single distance unit and palette RAM read port.
// Reset is synchronous; it empties the cache and restores the search bound and the LFSR.
// A stalled output word holds the next lookup in the emit state until the word is taken.
`include "cached_nearest_palette_color_top_defines.svh"

module cached_nearest_palette_color_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [cnpc_pkg::CFG_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [cnpc_pkg::IDX_W-1:0]    entry_index,
  input  logic [cnpc_pkg::COMP_W-1:0]   red,
  input  logic [cnpc_pkg::COMP_W-1:0]   green,
  input  logic [cnpc_pkg::COMP_W-1:0]   blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cnpc_pkg::IDX_W-1:0]    color_index,
  output logic                          cache_hit
);

  localparam int PAL_AW    = cnpc_pkg::PAL_AW;
  localparam int CACHE_AW  = cnpc_pkg::CACHE_AW;
  localparam int FILL_W    = cnpc_pkg::FILL_W;
  localparam int LFSR_BITS = cnpc_pkg::LFSR_BITS;
  localparam int PROD_W    = LFSR_BITS + FILL_W;

  cnpc_pkg::state_t state, state_next;

  logic [cnpc_pkg::CFG_W-1:0]  last_searched_index;
  logic [PAL_AW-1:0]           last_clamped;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           ci;
  logic [FILL_W-1:0]           ci_inc;
  logic [CACHE_AW-1:0]         ci_prev;
  logic [LFSR_BITS-1:0]        lfsr;
  logic [LFSR_BITS-1:0]        lfsr_next;
  logic [PROD_W-1:0]           slot_prod;
  logic [CACHE_AW-1:0]         slot;
  logic                        cache_full;

  cnpc_pkg::color_t            query;
  cnpc_pkg::cache_entry_t      prev_entry;
  logic [PAL_AW-1:0]           pi;
  logic [PAL_AW-1:0]           pi_inc;
  logic [PAL_AW-1:0]           best_idx;
  logic [cnpc_pkg::DIST_W-1:0] best_dist;
  logic [cnpc_pkg::DIST_W-1:0] sq_dist;
  logic                        res_hit;
  logic                        take;
  logic                        hit;
  logic                        accept;
  logic                        out_free;

  logic                        pal_we;
  logic [PAL_AW-1:0]           pal_waddr;
  cnpc_pkg::color_t            pal_wdata;
  logic [PAL_AW-1:0]           pal_raddr;
  cnpc_pkg::color_t            pal_rdata;

  logic                        cache_we;
  logic [CACHE_AW-1:0]         cache_waddr;
  cnpc_pkg::cache_entry_t      cache_wdata;
  logic [CACHE_AW-1:0]         cache_raddr;
  cnpc_pkg::cache_entry_t      cache_rdata;

  cnpc_ram #(
    .WIDTH ($bits(cnpc_pkg::color_t)),
    .DEPTH (cnpc_pkg::PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  cnpc_ram #(
    .WIDTH ($bits(cnpc_pkg::cache_entry_t)),
    .DEPTH (cnpc_pkg::CACHE_ENTRIES)
  ) u_cache_ram (
    .clk   (clk),
    .we    (cache_we),
    .waddr (cache_waddr),
    .wdata (cache_wdata),
    .raddr (cache_raddr),
    .rdata (cache_rdata)
  );

  cnpc_dist u_dist (
    .query   (query),
    .entry   (pal_rdata),
    .sq_dist (sq_dist)
  );

  assign in_ready = (state == cnpc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign ci_inc  = ci + 1'b1;
  assign ci_prev = ci[CACHE_AW-1:0] - 1'b1;
  assign pi_inc  = pi + 1'b1;
  assign hit     = (cache_rdata.color == query);
  assign take    = (pi == '0) || (sq_dist < best_dist);

  assign cache_full = !(32'(fill) < cnpc_pkg::CACHE_ENTRIES);
  assign lfsr_next  = {lfsr[LFSR_BITS-2:0], lfsr[LFSR_BITS-1] ^ lfsr[LFSR_BITS-2]};
  // Scaling the LFSR value by the cache size and keeping the high part picks the slot.
  assign slot_prod  = {{FILL_W{1'b0}}, lfsr_next} * PROD_W'(cnpc_pkg::CACHE_ENTRIES);
  assign slot       = slot_prod[LFSR_BITS +: CACHE_AW];

  always_comb begin
    if (32'(last_searched_index) > cnpc_pkg::PALETTE_ENTRIES - 1) begin
      last_clamped = PAL_AW'(cnpc_pkg::PALETTE_ENTRIES - 1);
    end else begin
      last_clamped = last_searched_index[PAL_AW-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    pal_we      = 1'b0;
    pal_waddr   = entry_index[PAL_AW-1:0];
    pal_wdata   = cnpc_pkg::color_t'{r: red, g: green, b: blue};
    pal_raddr   = '0;
    cache_we    = 1'b0;
    cache_waddr = ci[CACHE_AW-1:0];
    cache_wdata = cache_rdata;
    cache_raddr = ci_inc[CACHE_AW-1:0];
    case (state)
      cnpc_pkg::ST_IDLE: begin
        cache_raddr = '0;
        if (accept) begin
          if (kind == cnpc_pkg::KIND_WRITE) begin
            pal_we = (32'(entry_index) < cnpc_pkg::PALETTE_ENTRIES);
          end else if (fill == '0) begin
            state_next = cnpc_pkg::ST_PSCAN;
          end else begin
            state_next = cnpc_pkg::ST_CSCAN;
          end
        end
      end
      cnpc_pkg::ST_CSCAN: begin
        if (hit) begin
          if (32'(ci) > cnpc_pkg::SWAP_ABOVE) begin
            // Move the hit entry one place forward; the old occupant follows next cycle.
            cache_we    = 1'b1;
            cache_waddr = ci_prev;
            cache_wdata = cache_rdata;
            state_next  = cnpc_pkg::ST_SWAP;
          end else begin
            state_next = cnpc_pkg::ST_EMIT;
          end
        end else if (ci_inc == fill) begin
          state_next = cnpc_pkg::ST_PSCAN;
        end
      end
      cnpc_pkg::ST_SWAP: begin
        cache_we    = 1'b1;
        cache_wdata = prev_entry;
        state_next  = cnpc_pkg::ST_EMIT;
      end
      cnpc_pkg::ST_PSCAN: begin
        pal_raddr = pi_inc;
        if (pi == last_clamped) begin
          state_next = cnpc_pkg::ST_STORE;
        end
      end
      cnpc_pkg::ST_STORE: begin
        cache_we    = 1'b1;
        cache_waddr = cache_full ? slot : fill[CACHE_AW-1:0];
        cache_wdata = cnpc_pkg::cache_entry_t'{color: query, idx: best_idx};
        state_next  = cnpc_pkg::ST_EMIT;
      end
      cnpc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = cnpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cnpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= cnpc_pkg::ST_IDLE;
      last_searched_index <= cnpc_pkg::LAST_INDEX_RESET;
      fill                <= '0;
      lfsr                <= cnpc_pkg::LFSR_RESET;
      out_valid           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        last_searched_index <= cfg_write_data;
      end
      if (accept && kind == cnpc_pkg::KIND_WRITE) begin
        fill <= '0;
      end else if (state == cnpc_pkg::ST_STORE) begin
        if (cache_full) begin
          lfsr <= lfsr_next;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      if (state == cnpc_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cnpc_pkg::ST_IDLE: begin
        query <= cnpc_pkg::color_t'{r: red, g: green, b: blue};
        ci    <= '0;
        pi    <= '0;
      end
      cnpc_pkg::ST_CSCAN: begin
        if (hit) begin
          best_idx <= cache_rdata.idx;
          res_hit  <= 1'b1;
        end else begin
          // Keep the line in front of the next one tested, for a possible swap.
          prev_entry <= cache_rdata;
          ci         <= ci_inc;
        end
      end
      cnpc_pkg::ST_PSCAN: begin
        res_hit <= 1'b0;
        pi      <= pi_inc;
        if (take) begin
          best_dist <= sq_dist;
          best_idx  <= pi;
        end
      end
      cnpc_pkg::ST_EMIT: begin
        if (out_free) begin
          color_index <= cnpc_pkg::IDX_W'(best_idx);
          cache_hit   <= res_hit;
        end
      end
      default: begin
      end
    endcase
  end

  `CNPC_ASSERT(a_fill_bound, 32'(fill) <= cnpc_pkg::CACHE_ENTRIES, "cache fill beyond capacity")
  `CNPC_ASSERT_NEXT(a_write_empties, accept && kind == cnpc_pkg::KIND_WRITE, fill == '0, "palette write kept cache")
  `CNPC_ASSERT(a_out_from_emit, $rose(out_valid) |-> $past(state == cnpc_pkg::ST_EMIT), "stray word")
  `CNPC_ASSERT(a_scan_bound, (state == cnpc_pkg::ST_PSCAN) |-> (pi <= last_clamped), "scan overrun")
  `CNPC_ASSERT(a_swap_pos, (state == cnpc_pkg::ST_SWAP) |-> (32'(ci) > cnpc_pkg::SWAP_ABOVE), "bad swap")

endmodule
